@@ hdl/csjt_pkg.sv @@
// Shared types and constants for the cubic spline joint tracker.
package csjt_pkg;

  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_TARGET   = 3'd1;
  localparam logic [2:0] REG_COEF_SQ  = 3'd2;
  localparam logic [2:0] REG_COEF_CU  = 3'd3;
  localparam logic [2:0] REG_GAIN_POS = 3'd4;
  localparam logic [2:0] REG_GAIN_VEL = 3'd5;

  localparam logic signed [53:0] TORQUE_MAX = 54'sd8388607;
  localparam logic signed [53:0] TORQUE_MIN = -54'sd8388608;

  typedef struct packed {
    logic        [19:0] duration;
    logic signed [15:0] target_position;
    logic signed [23:0] coef_quadratic;
    logic signed [23:0] coef_cubic;
    logic        [15:0] gain_position;
    logic        [15:0] gain_velocity;
  } cfg_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] q;
    logic signed [15:0] dq;
    logic signed [23:0] g;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [52:0] pa;
    logic signed [42:0] ph;
    logic signed [42:0] pl;
    logic signed [55:0] va;
  } poly_t;

endpackage

@@ hdl/csjt_poly.sv @@
// Spline pipeline: time powers and coefficient products over three stages.
module csjt_poly (
  input  logic               clk,
  input  logic               rst,
  input  csjt_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [19:0] t,
  input  logic signed [15:0] q,
  input  logic signed [15:0] dq,
  input  logic signed [23:0] g,
  output logic               out_valid,
  input  logic               out_stall,
  output csjt_pkg::poly_t    res
);
  import csjt_pkg::*;

  logic v1, v2;
  logic en1, en2, en3;

  logic        [19:0] s1_t;
  logic        [27:0] s1_t2;
  side_t              s1_side;

  logic        [35:0] s2_t3;
  logic signed [52:0] s2_pa;
  logic signed [55:0] s2_va;
  side_t              s2_side;

  logic        [39:0] tt;
  logic        [47:0] t3full;
  logic signed [20:0] t_s;
  logic signed [28:0] t2_s;
  logic signed [23:0] a2, a3;
  logic signed [44:0] a2t;
  logic signed [52:0] a3t2;
  logic signed [55:0] va_next;
  logic signed [18:0] hi_s, lo_s;

  assign a2 = cfg.coef_quadratic;
  assign a3 = cfg.coef_cubic;

  assign en3 = ~out_valid | ~out_stall;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;
  assign in_stall = ~en1;

  assign tt = {20'd0, t} * {20'd0, t};

  assign t3full = {20'd0, s1_t2} * {28'd0, s1_t};
  assign t_s  = {1'b0, s1_t};
  assign t2_s = {1'b0, s1_t2};
  assign a2t  = a2 * t_s;
  assign a3t2 = a3 * t2_s;
  assign va_next = (56'(a2t) <<< 1) + 56'(a3t2) + (56'(a3t2) <<< 1);

  assign hi_s = {1'b0, s2_t3[35:18]};
  assign lo_s = {1'b0, s2_t3[17:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_t <= t;
      s1_t2 <= tt[39:12];
      s1_side.done <= (t > cfg.duration);
      s1_side.q <= q;
      s1_side.dq <= dq;
      s1_side.g <= g;
    end
    if (en2) begin
      s2_t3 <= t3full[47:12];
      s2_pa <= a2 * t2_s;
      s2_va <= va_next;
      s2_side <= s1_side;
    end
    if (en3) begin
      res.side <= s2_side;
      res.pa <= s2_pa;
      res.ph <= a3 * hi_s;
      res.pl <= a3 * lo_s;
      res.va <= s2_va;
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_stall |-> (v1 && v2 && out_valid))
    else $error("poly stall with an empty stage");
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid)
    else $error("poly result dropped while held");
  assert property (@(posedge clk) rst |=> (!v1 && !v2 && !out_valid))
    else $error("poly valid after reset");

endmodule

@@ hdl/csjt_law.sv @@
// Control law pipeline: errors, gain products, rounding and saturation.
module csjt_law (
  input  logic               clk,
  input  logic               rst,
  input  csjt_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  csjt_pkg::poly_t    src,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] drive_torque,
  output logic               move_done,
  output logic               saturated
);
  import csjt_pkg::*;

  logic v4, v5;
  logic en4, en5, en6;

  logic signed [42:0] s4_ep;
  logic signed [37:0] s4_ev;
  logic               s4_done;
  logic signed [23:0] s4_g;

  logic signed [59:0] s5_mp;
  logic signed [54:0] s5_mv;
  logic               s5_done;
  logic signed [23:0] s5_g;

  logic signed [52:0] pa;
  logic signed [42:0] ph, pl;
  logic signed [55:0] va;
  logic signed [15:0] q, dq, tp;
  logic signed [61:0] psum;
  logic signed [56:0] vsum;
  logic signed [41:0] pos;
  logic signed [36:0] vel;
  logic signed [42:0] ep_next;
  logic signed [37:0] ev_next;
  logic signed [16:0] kp_s, kv_s;
  logic signed [60:0] msum;
  logic signed [53:0] tq;

  assign pa = src.pa;
  assign ph = src.ph;
  assign pl = src.pl;
  assign va = src.va;
  assign q  = src.side.q;
  assign dq = src.side.dq;
  assign tp = cfg.target_position;
  assign kp_s = {1'b0, cfg.gain_position};
  assign kv_s = {1'b0, cfg.gain_velocity};

  assign en6 = ~out_valid | ~out_stall;
  assign en5 = ~v5 | en6;
  assign en4 = ~v4 | en5;
  assign in_stall = ~en4;

  assign psum = 62'(pa) + (62'(ph) <<< 18) + 62'(pl) + 62'sd524288;
  assign vsum = 57'(va) + 57'sd524288;
  assign pos  = psum[61:20];
  assign vel  = vsum[56:20];

  always_comb begin
    if (src.side.done) begin
      ep_next = 43'(tp) - 43'(q);
      ev_next = -38'(dq);
    end else begin
      ep_next = 43'(pos) - 43'(q);
      ev_next = 38'(vel) - 38'(dq);
    end
  end

  assign msum = 61'(s5_mp) + 61'(s5_mv) + 61'sd128;
  assign tq   = 54'(signed'(msum[60:8])) + 54'(s5_g);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_ep <= ep_next;
      s4_ev <= ev_next;
      s4_done <= src.side.done;
      s4_g <= src.side.g;
    end
    if (en5) begin
      s5_mp <= kp_s * s4_ep;
      s5_mv <= kv_s * s4_ev;
      s5_done <= s4_done;
      s5_g <= s4_g;
    end
    if (en6) begin
      move_done <= s5_done;
      if (tq > TORQUE_MAX) begin
        drive_torque <= TORQUE_MAX[23:0];
        saturated <= 1'b1;
      end else if (tq < TORQUE_MIN) begin
        drive_torque <= TORQUE_MIN[23:0];
        saturated <= 1'b1;
      end else begin
        drive_torque <= tq[23:0];
        saturated <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (drive_torque == TORQUE_MAX[23:0] ||
                                  drive_torque == TORQUE_MIN[23:0]))
    else $error("saturated flag without a clipped torque");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v5) |=> !out_valid)
    else $error("result repeated");
  assert property (@(posedge clk) rst |=> (!v4 && !v5 && !out_valid))
    else $error("law valid after reset");

endmodule

@@ hdl/cubic_spline_joint_tracker_unit.sv @@
// Top level of the cubic spline joint tracker: registers, spline and law pipelines.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  elapsed_time, joint_position, joint_velocity,
//                                            gravity_torque
//   out      from block out_valid / out_stall drive_torque, move_done, saturated
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle in and out while out_stall is low.
// Six register stages, three on each side, with a valid bit per stage.
// Empty stages fill while the output is stalled; in_stall rises only when all six are full.
// Reset empties the pipeline and zeroes the config registers; cfg_ready is always high.
module cubic_spline_joint_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [19:0] elapsed_time,
  input  logic signed [15:0] joint_position,
  input  logic signed [15:0] joint_velocity,
  input  logic signed [23:0] gravity_torque,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] drive_torque,
  output logic               move_done,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [23:0] cfg_data
);
  import csjt_pkg::*;

  cfg_t  cfg;
  poly_t mid;
  logic  mid_valid;
  logic  mid_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DURATION: cfg.duration <= cfg_data[19:0];
        REG_TARGET:   cfg.target_position <= cfg_data[15:0];
        REG_COEF_SQ:  cfg.coef_quadratic <= cfg_data;
        REG_COEF_CU:  cfg.coef_cubic <= cfg_data;
        REG_GAIN_POS: cfg.gain_position <= cfg_data[15:0];
        REG_GAIN_VEL: cfg.gain_velocity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  csjt_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .t         (elapsed_time),
    .q         (joint_position),
    .dq        (joint_velocity),
    .g         (gravity_torque),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .res       (mid)
  );

  csjt_law u_law (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (mid_valid),
    .in_stall     (mid_stall),
    .src          (mid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_torque (drive_torque),
    .move_done    (move_done),
    .saturated    (saturated)
  );

  assert property (@(posedge clk) disable iff (rst) in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output moves");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the cubic spline joint tracker: random and directed servo ticks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csjt_pkg::*;

  localparam int unsigned TICK_LIMIT = 200000;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic        [19:0] t;
    logic signed [15:0] q;
    logic signed [15:0] dq;
    logic signed [23:0] g;
  } joint_sample_t;

  typedef struct packed {
    logic signed [23:0] torque;
    logic               done;
    logic               sat;
  } torque_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [19:0] elapsed_time = '0;
  logic signed [15:0] joint_position = '0;
  logic signed [15:0] joint_velocity = '0;
  logic signed [23:0] gravity_torque = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] drive_torque;
  logic               move_done;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index = '0;
  logic        [23:0] cfg_data = '0;

  cfg_t            track_cfg = '0;
  joint_sample_t   pending_samples[$];
  torque_result_t  expected_drive[$];
  int unsigned     sender_idle_pct = 26;
  int unsigned     receiver_stall_pct = 50;
  int unsigned     errors = 0;
  int unsigned     tick_count = 0;

  cubic_spline_joint_tracker_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .elapsed_time   (elapsed_time),
    .joint_position (joint_position),
    .joint_velocity (joint_velocity),
    .gravity_torque (gravity_torque),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_torque   (drive_torque),
    .move_done      (move_done),
    .saturated      (saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic torque_result_t predict_drive(cfg_t c, logic [19:0] t,
                                                   logic signed [15:0] q,
                                                   logic signed [15:0] dq,
                                                   logic signed [23:0] g);
    longint tl, qv, dqv, gv, kp, kv, a2, a3, tgt;
    longint t2, t3, p, v, ep, ev, tq;
    torque_result_t r;
    tl  = {44'd0, t};
    qv  = q;
    dqv = dq;
    gv  = g;
    kp  = {48'd0, c.gain_position};
    kv  = {48'd0, c.gain_velocity};
    a2  = c.coef_quadratic;
    a3  = c.coef_cubic;
    tgt = c.target_position;
    r.done = (t > c.duration);
    if (r.done) begin
      ep = tgt - qv;
      ev = -dqv;
    end else begin
      t2 = (tl * tl) >>> 12;
      t3 = (t2 * tl) >>> 12;
      p  = (a2 * t2 + a3 * t3 + 64'sd524288) >>> 20;
      v  = (64'sd2 * a2 * tl + 64'sd3 * a3 * t2 + 64'sd524288) >>> 20;
      ep = p - qv;
      ev = v - dqv;
    end
    tq = ((kp * ep + kv * ev + 64'sd128) >>> 8) + gv;
    r.sat = 1'b1;
    if (tq > 64'sd8388607) tq = 64'sd8388607;
    else if (tq < -64'sd8388608) tq = -64'sd8388608;
    else r.sat = 1'b0;
    r.torque = tq[23:0];
    return r;
  endfunction

  function automatic cfg_t random_setting(bit realistic);
    cfg_t c;
    if (realistic) begin
      c.duration        = 20'($urandom_range(20000, 1));
      c.target_position = 16'(int'($urandom_range(8192)) - 4096);
      c.coef_quadratic  = 24'(int'($urandom_range(524288)) - 262144);
      c.coef_cubic      = 24'(int'($urandom_range(524288)) - 262144);
      c.gain_position   = 16'($urandom_range(4096));
      c.gain_velocity   = 16'($urandom_range(4096));
    end else begin
      c.duration        = 20'($urandom);
      c.target_position = 16'($urandom);
      c.coef_quadratic  = 24'($urandom);
      c.coef_cubic      = 24'($urandom);
      c.gain_position   = 16'($urandom);
      c.gain_velocity   = 16'($urandom);
    end
    return c;
  endfunction

  task automatic add_sample(logic [19:0] t, logic signed [15:0] q, logic signed [15:0] dq,
                            logic signed [23:0] g);
    joint_sample_t s;
    s.t  = t;
    s.q  = q;
    s.dq = dq;
    s.g  = g;
    pending_samples.push_back(s);
  endtask

  task automatic add_random_sample();
    joint_sample_t s;
    longint        reach;
    int unsigned   pick;
    reach = longint'(track_cfg.duration) + longint'(track_cfg.duration) / 4 + 4;
    if (reach > 1048575) reach = 1048575;
    pick = $urandom_range(99);
    if (pick < 75) s.t = 20'($urandom_range(int'(reach)));
    else if (pick < 85) s.t = 20'(track_cfg.duration + $urandom_range(1));
    else s.t = 20'($urandom);
    if ($urandom_range(99) < 70) s.q = 16'(int'($urandom_range(8192)) - 4096);
    else s.q = 16'($urandom);
    if ($urandom_range(99) < 70) s.dq = 16'(int'($urandom_range(8192)) - 4096);
    else s.dq = 16'($urandom);
    if ($urandom_range(99) < 70) s.g = 24'(int'($urandom_range(131072)) - 65536);
    else s.g = 24'($urandom);
    pending_samples.push_back(s);
  endtask

  task automatic write_register(logic [2:0] idx, logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DURATION: track_cfg.duration        = data[19:0];
      REG_TARGET:   track_cfg.target_position = data[15:0];
      REG_COEF_SQ:  track_cfg.coef_quadratic  = data;
      REG_COEF_CU:  track_cfg.coef_cubic      = data;
      REG_GAIN_POS: track_cfg.gain_position   = data[15:0];
      REG_GAIN_VEL: track_cfg.gain_velocity   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(cfg_t c);
    write_register(REG_DURATION, {4'd0, c.duration});
    write_register(REG_TARGET, {{8{c.target_position[15]}}, c.target_position});
    write_register(REG_COEF_SQ, c.coef_quadratic);
    write_register(REG_COEF_CU, c.coef_cubic);
    write_register(REG_GAIN_POS, {8'd0, c.gain_position});
    write_register(REG_GAIN_VEL, {8'd0, c.gain_velocity});
  endtask

  // hold until every queued transaction has come back out
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || expected_drive.size() != 0);
  endtask

  always @(posedge clk) begin : driver
    joint_sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_drive.push_back(predict_drive(track_cfg, elapsed_time, joint_position,
                                               joint_velocity, gravity_torque));
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s = pending_samples.pop_front();
          in_valid       <= 1'b1;
          elapsed_time   <= s.t;
          joint_position <= s.q;
          joint_velocity <= s.dq;
          gravity_torque <= s.g;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    torque_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          if (errors < 10)
            $display("tb_top: unexpected result torque=%0d done=%0b sat=%0b",
                     drive_torque, move_done, saturated);
          errors++;
        end else begin
          want = expected_drive.pop_front();
          if (drive_torque !== want.torque || move_done !== want.done ||
              saturated !== want.sat) begin
            if (errors < 10)
              $display("tb_top: mismatch torque exp=%0d got=%0d done exp=%0b got=%0b sat exp=%0b got=%0b",
                       want.torque, drive_torque, want.done, move_done, want.sat, saturated);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count == TICK_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t setting;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: torque is gravity alone
    add_sample(20'h00000, 16'sh0000, 16'sh0000, 24'sh7FFFFF);
    add_sample(20'h00001, 16'sh8000, 16'sh7FFF, 24'sh800000);
    settle();

    setting = '{duration: 20'h08000, target_position: 16'sh1000,
                coef_quadratic: 24'sh100000, coef_cubic: -24'sh080000,
                gain_position: 16'h0400, gain_velocity: 16'h0100};
    apply_setting(setting);
    add_sample(20'h00000, 16'sh0000, 16'sh0000, 24'sh000000);
    add_sample(20'h08000, 16'sh0800, 16'sh0100, 24'sh000000);
    add_sample(20'h08001, 16'sh0800, -16'sh0100, 24'sh000000);
    add_sample(20'hFFFFF, 16'sh7FFF, 16'sh7FFF, 24'sh000100);
    add_sample(20'h04000, 16'sh8000, 16'sh8000, 24'sh7FFFFF);
    add_sample(20'h04000, 16'sh7FFF, 16'sh7FFF, 24'sh800000);
    add_sample(20'h00001, 16'sh0000, 16'sh0000, 24'sh7FFFFF);
    settle();

    // zero duration with extreme gains; writes to unused indexes must be dropped
    setting = '{duration: 20'h00000, target_position: 16'sh8000,
                coef_quadratic: 24'sh7FFFFF, coef_cubic: 24'sh800000,
                gain_position: 16'hFFFF, gain_velocity: 16'hFFFF};
    apply_setting(setting);
    write_register(REG_UNUSED_LO, 24'hFFFFFF);
    write_register(REG_UNUSED_HI, 24'h123456);
    add_sample(20'h00000, 16'sh7FFF, 16'sh8000, 24'sh000000);
    add_sample(20'h00001, 16'sh7FFF, 16'sh0000, 24'sh000000);
    add_sample(20'hFFFFF, 16'sh7FFF, 16'sh7FFF, 24'sh000000);
    add_sample(20'h00000, 16'sh8000, 16'sh7FFF, 24'sh800000);
    settle();

    setting = '{duration: 20'hFFFFF, target_position: 16'sh7FFF,
                coef_quadratic: 24'sh800000, coef_cubic: 24'sh7FFFFF,
                gain_position: 16'h0001, gain_velocity: 16'h0000};
    apply_setting(setting);
    add_sample(20'hFFFFF, 16'sh0000, 16'sh0000, 24'sh000000);
    add_sample(20'h80000, 16'sh8000, 16'sh0000, 24'sh000000);
    add_sample(20'h00001, 16'sh0000, 16'sh0000, 24'sh000000);
    add_sample(20'h00FFF, 16'sh1234, 16'sh8000, 24'sh000001);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      if (phase < 2) begin
        sender_idle_pct    = 26;
        receiver_stall_pct = 50;
      end else if (phase < 4) begin
        sender_idle_pct    = 50;
        receiver_stall_pct = 26;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      apply_setting(random_setting(phase % 3 != 2));
      // pause the sender halfway until the pipeline has drained
      repeat (125) add_random_sample();
      settle();
      repeat (125) add_random_sample();
      settle();
    end

    repeat (12) @(posedge clk);
    if (expected_drive.size() != 0) errors++;
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hdl/csjt_pkg.sv
hdl/csjt_poly.sv
hdl/csjt_law.sv
hdl/cubic_spline_joint_tracker_unit.sv
dv/tb_top.sv
